>>> rtl/lsbme_pkg.sv
package lsbme_pkg;

	// Configuration register widths and indexes
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	// Geometry defaults
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Pixel and message layout
	localparam int COLOR_W   = 8;
	localparam int PIXEL_W   = 3 * COLOR_W;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 32;
	localparam int HDR_CNT_W = $clog2(LEN_W);
	localparam int BIT_IDX_W = $clog2(BYTE_W);

	// Capacity arithmetic: 13 x 13 product, times three, then bytes after the header
	localparam int PROD_W = 2 * CFG_DATA_W;
	localparam int CAP_W  = PROD_W + 2;
	localparam int LIM_W  = CAP_W - 3;

endpackage

>>> rtl/lsb_message_extractor.sv
// Each pixel is held in the input register, and its result in the output register.
// Throughput: one pixel per cycle; the single decode stage sets the rate and
// stalls only when the output register holds a result that is not taken.
// Reset (arst_n low, asynchronous): decoder in header phase with all counts zero,
// output empty, image_width and image_height both 1.
module lsb_message_extractor
	import lsbme_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// pixel input
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIXEL_W-1:0]    s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic                  s_tuser,   // first_pixel
	// message output
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [BYTE_W-1:0]     m_tdata,   // message_byte [7:0]
	output logic                  m_tuser,   // status
	output logic                  m_tlast,   // last
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_MESSAGE = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	// Configuration registers
	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [LIM_W-1:0]      lim_q;

	// Input register
	logic                  valid_s1;
	logic                  first_s1;
	logic [2:0]            bits_s1;

	// Decode state
	phase_t                phase_q;
	logic [HDR_CNT_W-1:0]  hdr_cnt_q;
	logic [LEN_W-1:0]      len_q;
	logic [BYTE_W-1:0]     acc_q;
	logic [BIT_IDX_W-1:0]  bit_j_q;
	logic [LIM_W-1:0]      byte_cnt_q;

	// Output register
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_status_q;
	logic                  out_last_q;

	// Next-state values
	phase_t                ph_n;
	logic [HDR_CNT_W-1:0]  hdr_cnt_n;
	logic [LEN_W-1:0]      len_n;
	logic [BYTE_W-1:0]     acc_n;
	logic [BIT_IDX_W-1:0]  bit_j_n;
	logic [LIM_W-1:0]      byte_cnt_n;
	logic                  res_valid;
	logic [BYTE_W-1:0]     res_byte;
	logic                  res_status;
	logic                  res_last;

	logic                  fire;
	logic [CFG_DATA_W-1:0] w_eff, h_eff;
	logic [PROD_W-1:0]     prod;
	logic [CAP_W-1:0]      cap;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || fire;

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_byte_q;
	assign m_tuser   = out_status_q;
	assign m_tlast   = out_last_q;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DATA_W'(1);
			height_q <= CFG_DATA_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp geometry and derive the capacity in bits
	always_comb begin
		w_eff = (32'(width_q) > MAX_WIDTH) ? CFG_DATA_W'(MAX_WIDTH) : width_q;
		h_eff = (32'(height_q) > MAX_HEIGHT) ? CFG_DATA_W'(MAX_HEIGHT) : height_q;
		prod  = PROD_W'(w_eff) * PROD_W'(h_eff);
		cap   = CAP_W'(prod) + CAP_W'({prod, 1'b0});
	end

	// Hold the length limit; it is registered from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
		end else if (cap >= CAP_W'(LEN_W)) begin
			lim_q <= LIM_W'((cap - CAP_W'(LEN_W)) >> 3);
		end else begin
			lim_q <= '0;
		end
	end

	// Register the incoming pixel, keeping only the low bit of each color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			first_s1 <= s_tuser;
			bits_s1  <= {s_tdata[2*COLOR_W], s_tdata[COLOR_W], s_tdata[0]};
		end
	end

	// Decode the three bits of one pixel: red, green, then blue
	always_comb begin
		ph_n       = phase_q;
		hdr_cnt_n  = hdr_cnt_q;
		len_n      = len_q;
		acc_n      = acc_q;
		bit_j_n    = bit_j_q;
		byte_cnt_n = byte_cnt_q;
		res_valid  = 1'b0;
		res_byte   = '0;
		res_status = 1'b0;
		res_last   = 1'b0;

		if (first_s1) begin
			ph_n       = PH_HEADER;
			hdr_cnt_n  = '0;
			len_n      = '0;
			acc_n      = '0;
			bit_j_n    = '0;
			byte_cnt_n = '0;
		end

		for (int i = 0; i < 3; i++) begin
			case (ph_n)
				PH_HEADER: begin
					len_n[hdr_cnt_n] = bits_s1[i];
					if (hdr_cnt_n == HDR_CNT_W'(LEN_W - 1)) begin
						if (len_n == '0 || len_n[LEN_W-1] ||
						    len_n[LEN_W-2:0] > (LEN_W-1)'(lim_q)) begin
							ph_n       = PH_DONE;
							res_valid  = 1'b1;
							res_byte   = '0;
							res_status = 1'b1;
							res_last   = 1'b1;
						end else begin
							ph_n       = PH_MESSAGE;
							acc_n      = '0;
							bit_j_n    = '0;
							byte_cnt_n = '0;
						end
					end
					hdr_cnt_n = hdr_cnt_n + HDR_CNT_W'(1);
				end
				PH_MESSAGE: begin
					acc_n[bit_j_n] = bits_s1[i];
					if (bit_j_n == BIT_IDX_W'(BYTE_W - 1)) begin
						byte_cnt_n = byte_cnt_n + LIM_W'(1);
						res_valid  = 1'b1;
						res_byte   = acc_n;
						res_status = 1'b0;
						res_last   = (LEN_W'(byte_cnt_n) >= len_n);
						acc_n      = '0;
						if (res_last) begin
							ph_n = PH_DONE;
						end
					end
					bit_j_n = bit_j_n + BIT_IDX_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Advance decode state when the pixel moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			len_q      <= '0;
			acc_q      <= '0;
			bit_j_q    <= '0;
			byte_cnt_q <= '0;
		end else if (fire) begin
			phase_q    <= ph_n;
			hdr_cnt_q  <= hdr_cnt_n;
			len_q      <= len_n;
			acc_q      <= acc_n;
			bit_j_q    <= bit_j_n;
			byte_cnt_q <= byte_cnt_n;
		end
	end

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q   <= res_byte;
			out_status_q <= res_status;
			out_last_q   <= res_last;
		end
	end

	// An error result always closes the message and carries a zero byte
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
		else $error("error result without last or with nonzero byte");

	// A finished message yields nothing until the next first pixel
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !first_s1 && phase_q == PH_DONE) |=> !m_tvalid)
		else $error("result produced after message end");

	// Message counters stay clear while the header is gathered
	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (bit_j_q == '0 && byte_cnt_q == '0))
		else $error("byte counters not clear in header phase");

endmodule
